// ===== src/pru_pkg.sv =====
package pru_pkg;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  typedef enum logic [1:0] {
    REG_BPP       = 2'd0,
    REG_ROW_BYTES = 2'd1
  } reg_idx_t;

  // what travels with a byte from the input stage to the reconstruction stage
  typedef struct packed {
    logic is_filter;
    logic last;
    logic start;
  } item_tag_t;

  function automatic filt_t decode_filter(input logic [7:0] code);
    filt_t f;
    case (code)
      8'd1:    f = FILT_SUB;
      8'd2:    f = FILT_UP;
      8'd3:    f = FILT_AVG;
      8'd4:    f = FILT_PAETH;
      default: f = FILT_NONE;
    endcase
    return f;
  endfunction

endpackage

// ===== src/png_row_unfilter.sv =====
// PNG scanline unfilter: takes one filtered stream byte per cycle while results are
// drained and returns one reconstructed byte for every data byte, none for a row's
// filter-type byte. An item passes an input stage, where the line store read for its
// column is issued, and a reconstruction stage that loads the output register.
// The line store is MAX_ROW_BYTES x 8 with one write and one registered read port and
// holds the previous row; it is not cleared after reset, so the first row after an
// image start uses zeros instead, and every later row must be no longer than the one
// before it. The user must write bytes_per_pixel and row_bytes through the config
// channel only while no item is in flight; the block does not enforce it.
module png_row_unfilter #(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_byte,
  output logic        row_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int PW = 17;
  localparam logic [PW-1:0] MAX_ROWS = PW'(MAX_ROW_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ROW_BYTES - 1);

  logic [2:0]  bytes_per_pixel;
  logic [13:0] row_bytes;

  logic [PW-1:0] rb_eff;
  logic [13:0]   byte_position;
  logic [13:0]   byte_position_next;
  logic [PW-1:0] pos_m1;
  logic [AW-1:0] rd_addr;
  logic          front_last;
  logic          in_accept;

  logic                 s1_valid;
  pru_pkg::item_tag_t   s1_tag;
  logic [7:0]           s1_data;
  logic [AW-1:0]        s1_idx;
  logic                 s1_go;

  pru_pkg::filt_t current_filter;
  logic [31:0]    left_history;
  logic [31:0]    upper_left_history;
  logic           first_row_flag;

  logic [7:0] rd_data;
  logic [1:0] sel;
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [7:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd1;
      row_bytes       <= 14'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pru_pkg::REG_BPP:       bytes_per_pixel <= cfg_data[2:0];
        pru_pkg::REG_ROW_BYTES: row_bytes       <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: row position and store read address
  always_comb begin
    if (row_bytes == 14'd0) begin
      rb_eff = PW'(1);
    end else if ({3'b000, row_bytes} > MAX_ROWS) begin
      rb_eff = MAX_ROWS;
    end else begin
      rb_eff = {3'b000, row_bytes};
    end
    pos_m1     = {3'b000, byte_position} - PW'(1);
    rd_addr    = (pos_m1 >= MAX_ROWS) ? LAST_IDX : pos_m1[AW-1:0];
    front_last = {3'b000, byte_position} >= rb_eff;
    if (byte_position == 14'd0) begin
      byte_position_next = 14'd1;
    end else if (front_last) begin
      byte_position_next = 14'd0;
    end else begin
      byte_position_next = byte_position + 14'd1;
    end
  end

  assign s1_go     = s1_valid && (s1_tag.is_filter || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      byte_position <= 14'd0;
    end else if (in_accept) begin
      s1_valid      <= 1'b1;
      byte_position <= byte_position_next;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_tag.is_filter <= (byte_position == 14'd0);
      s1_tag.last      <= front_last;
      s1_tag.start     <= image_start;
      s1_data          <= data_byte;
      s1_idx           <= rd_addr;
    end
  end

  pru_line_store #(
    .DEPTH(MAX_ROW_BYTES),
    .AW   (AW)
  ) u_line_store (
    .clk    (clk),
    .wr_en  (s1_go && !s1_tag.is_filter),
    .wr_addr(s1_idx),
    .wr_data(res),
    .rd_en  (in_accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // reconstruction stage
  always_comb begin
    if (bytes_per_pixel == 3'd0) begin
      sel = 2'd0;
    end else if (bytes_per_pixel > 3'd4) begin
      sel = 2'd3;
    end else begin
      sel = 2'(bytes_per_pixel - 3'd1);
    end
    a = left_history[{sel, 3'b000} +: 8];
    c = upper_left_history[{sel, 3'b000} +: 8];
    b = first_row_flag ? 8'd0 : rd_data;
  end

  pru_predictor u_predictor (
    .filter(current_filter),
    .d     (s1_data),
    .a     (a),
    .b     (b),
    .c     (c),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      current_filter     <= pru_pkg::FILT_NONE;
      left_history       <= 32'd0;
      upper_left_history <= 32'd0;
      first_row_flag     <= 1'b1;
    end else if (s1_go) begin
      if (s1_tag.is_filter) begin
        if (s1_tag.start) begin
          first_row_flag <= 1'b1;
        end
        current_filter     <= pru_pkg::decode_filter(s1_data);
        left_history       <= 32'd0;
        upper_left_history <= 32'd0;
      end else begin
        left_history       <= {left_history[23:0], res};
        upper_left_history <= {upper_left_history[23:0], b};
        if (s1_tag.last) begin
          first_row_flag <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && !s1_tag.is_filter) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_tag.is_filter) begin
      pixel_byte <= res;
      row_end    <= s1_tag.last;
    end
  end

  // input stalls only behind a data byte blocked by a full, untaken output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && !s1_tag.is_filter && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  // a filter byte never produces a result
  a_filter_silent: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_tag.is_filter && !out_valid |=> !out_valid)
    else $error("filter byte produced a result");

  // the last data byte of a row sends the position back to the filter byte
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    in_accept && byte_position != 14'd0 && front_last |=> byte_position == 14'd0)
    else $error("row position did not wrap after last byte");

endmodule

// ===== src/pru_line_store.sv =====
module pru_line_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pru_predictor.sv =====
module pru_predictor (
  input  pru_pkg::filt_t filter,
  input  logic [7:0]     d,
  input  logic [7:0]     a,
  input  logic [7:0]     b,
  input  logic [7:0]     c,
  output logic [7:0]     res
);

  logic signed [10:0] pa_s;
  logic signed [10:0] pb_s;
  logic signed [10:0] pc_s;
  logic [9:0]         pa;
  logic [9:0]         pb;
  logic [9:0]         pc;
  logic [7:0]         paeth;
  logic [8:0]         avg_sum;
  logic [7:0]         pred;

  always_comb begin
    pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
    pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
    pc_s = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa   = pa_s[10] ? 10'(-pa_s) : pa_s[9:0];
    pb   = pb_s[10] ? 10'(-pb_s) : pb_s[9:0];
    pc   = pc_s[10] ? 10'(-pc_s) : pc_s[9:0];
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
    avg_sum = {1'b0, a} + {1'b0, b};
    case (filter)
      pru_pkg::FILT_SUB:   pred = a;
      pru_pkg::FILT_UP:    pred = b;
      pru_pkg::FILT_AVG:   pred = avg_sum[8:1];
      pru_pkg::FILT_PAETH: pred = paeth;
      default:             pred = 8'd0;
    endcase
    res = d + pred;
  end

endmodule
